// File: hw/rtl/chip8_cpu_step_assert.svh
// Assertion macros for the CHIP-8 step engine.
// Each macro takes a label, an antecedent and a consequent.
`ifndef CHIP8_CPU_STEP_ASSERT_SVH
`define CHIP8_CPU_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define C8_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c8 check failed");
`define C8_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c8 check failed");
`else
`define C8_ASSERT_IMP(lbl, ante, cons)
`define C8_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/c8_pkg.sv
package c8_pkg;

   localparam int MEM_BYTES     = 4096;
   localparam int ADDR_W        = $clog2(MEM_BYTES);
   localparam int NUM_REGS      = 16;
   localparam int STACK_DEPTH   = 16;
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
   localparam int FONT_BYTES    = 80;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
   localparam logic [ADDR_W-1:0] START_PC  = 12'h200;

   // command codes on the request channel
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_EXEC = 2'd1;

   // item kinds after classification
   localparam logic [1:0] K_LOAD = 2'd0;
   localparam logic [1:0] K_EXEC = 2'd1;
   localparam logic [1:0] K_READ = 2'd2;

   // opcode groups (top nibble)
   localparam logic [3:0] OP_SYS   = 4'h0;
   localparam logic [3:0] OP_JP    = 4'h1;
   localparam logic [3:0] OP_CALL  = 4'h2;
   localparam logic [3:0] OP_SE    = 4'h3;
   localparam logic [3:0] OP_SNE   = 4'h4;
   localparam logic [3:0] OP_SEXY  = 4'h5;
   localparam logic [3:0] OP_LD    = 4'h6;
   localparam logic [3:0] OP_ADD   = 4'h7;
   localparam logic [3:0] OP_ALU   = 4'h8;
   localparam logic [3:0] OP_SNEXY = 4'h9;
   localparam logic [3:0] OP_LDI   = 4'hA;
   localparam logic [3:0] OP_JPV0  = 4'hB;
   localparam logic [3:0] OP_RND   = 4'hC;
   localparam logic [3:0] OP_DRW   = 4'hD;
   localparam logic [3:0] OP_SKP   = 4'hE;
   localparam logic [3:0] OP_MISC  = 4'hF;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   // ALU sub-codes (low nibble of 8xyN)
   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_RSB = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   // key skip codes and F-group low bytes
   localparam logic [7:0] SKP_DOWN = 8'h9E;
   localparam logic [7:0] SKP_UP   = 8'hA1;
   localparam logic [7:0] FX_GETDT = 8'h07;
   localparam logic [7:0] FX_KEY   = 8'h0A;
   localparam logic [7:0] FX_SETDT = 8'h15;
   localparam logic [7:0] FX_SETST = 8'h18;
   localparam logic [7:0] FX_ADDI  = 8'h1E;
   localparam logic [7:0] FX_FONT  = 8'h29;
   localparam logic [7:0] FX_BCD   = 8'h33;
   localparam logic [7:0] FX_STORE = 8'h55;
   localparam logic [7:0] FX_LOAD  = 8'h65;

   localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] load_addr;
      logic [7:0]        load_data;
      logic [ROW_W-1:0]  row_select;
      logic [15:0]       key_mask;
      logic [7:0]        rand_byte;
   } q_item_type;

   typedef struct packed {
      logic clearing;
   } stat_type;

   // power-up contents of main memory: font glyphs, zero elsewhere
   function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] off;
      off = a - FONT_BASE;
      if (a >= FONT_BASE && off < ADDR_W'(FONT_BYTES)) begin
         return GLYPHS[off[6:0]];
      end
      return 8'h00;
   endfunction

   // decimal digits {hundreds, tens, ones} of a byte
   function automatic logic [11:0] bcd_digits(input logic [7:0] v);
      logic [3:0]  h;
      logic [7:0]  rem;
      logic [14:0] prod;
      logic [3:0]  t;
      logic [7:0]  o;
      if (v >= 8'd200) begin
         h   = 4'd2;
         rem = v - 8'd200;
      end else if (v >= 8'd100) begin
         h   = 4'd1;
         rem = v - 8'd100;
      end else begin
         h   = 4'd0;
         rem = v;
      end
      prod = {7'b0, rem} * 15'd205;
      t    = prod[14:11];
      o    = rem - {t, 3'b0} - {3'b0, t, 1'b0};
      return {h, t, o[3:0]};
   endfunction

endpackage

// File: hw/rtl/c8_chan_if.sv
interface c8_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [11:0] load_addr;
   logic [7:0]  load_data;
   logic [4:0]  row_select;
   logic [15:0] key_mask;
   logic [7:0]  rand_byte;

   modport source(output valid, cmd, load_addr, load_data, row_select, key_mask,
                  rand_byte, input ready);
   modport sink(input valid, cmd, load_addr, load_data, row_select, key_mask,
                rand_byte, output ready);
endinterface

interface c8_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] row_pixels;
   logic [11:0] pc_now;
   logic        draw_flag;
   logic        sound_on;
   logic        key_wait;
   logic        bad_opcode;

   modport source(output valid, row_pixels, pc_now, draw_flag, sound_on, key_wait,
                  bad_opcode, input ready);
   modport sink(input valid, row_pixels, pc_now, draw_flag, sound_on, key_wait,
                bad_opcode, output ready);
endinterface

// File: hw/rtl/c8_front.sv
module c8_front import c8_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   c8_req_if.sink     req_ch,
   input  stat_type   stat,
   output logic       q_valid,
   output q_item_type q_item,
   input  logic       q_pop
);

   q_item_type        q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              push;
   logic              pop;
   q_item_type        item;

   // classify the incoming beat
   always_comb begin
      item.load_addr  = req_ch.load_addr;
      item.load_data  = req_ch.load_data;
      item.row_select = req_ch.row_select;
      item.key_mask   = req_ch.key_mask;
      item.rand_byte  = req_ch.rand_byte;
      unique case (req_ch.cmd)
         CMD_LOAD: item.kind = K_LOAD;
         CMD_EXEC: item.kind = K_EXEC;
         default:  item.kind = K_READ;
      endcase
   end

   // hold off while the queue is full or memory is being initialized
   assign req_ch.ready = (cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH)) && !stat.clearing;
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (cnt_ff != '0);
   assign pop          = q_pop && q_valid;
   assign q_item       = q_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: hw/rtl/c8_exec.sv
module c8_exec import c8_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  q_item_type q_item,
   output logic       q_pop,
   output stat_type   stat,
   c8_rsp_if.source   rsp_ch
);

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_FETCH_H = 5'd2;
   localparam logic [4:0] S_FETCH_L = 5'd3;
   localparam logic [4:0] S_READ_X  = 5'd4;
   localparam logic [4:0] S_READ_Y  = 5'd5;
   localparam logic [4:0] S_EXEC    = 5'd6;
   localparam logic [4:0] S_FLAG    = 5'd7;
   localparam logic [4:0] S_DRAW_A  = 5'd8;
   localparam logic [4:0] S_DRAW_B  = 5'd9;
   localparam logic [4:0] S_BCD     = 5'd10;
   localparam logic [4:0] S_STORE_A = 5'd11;
   localparam logic [4:0] S_STORE_B = 5'd12;
   localparam logic [4:0] S_LOAD_A  = 5'd13;
   localparam logic [4:0] S_LOAD_B  = 5'd14;
   localparam logic [4:0] S_ROW     = 5'd15;
   localparam logic [4:0] S_RESP    = 5'd16;

   // storage
   logic [7:0]                mem_ff   [MEM_BYTES];
   logic [7:0]                gp_ff    [NUM_REGS];
   logic [SCREEN_WIDTH-1:0]   frame_ff [SCREEN_HEIGHT];
   logic [ADDR_W-1:0]         stack_ff [STACK_DEPTH];
   logic [NUM_REGS-1:0]       gp_vld_ff;
   logic [SCREEN_HEIGHT-1:0]  fr_vld_ff;

   // read data
   logic [7:0]              mem_rd_ff;
   logic [7:0]              gp_rd_ff;
   logic                    gp_rdv_ff;
   logic [SCREEN_WIDTH-1:0] fr_rd_ff;
   logic                    fr_rdv_ff;
   logic [7:0]              gp_rdata;
   logic [SCREEN_WIDTH-1:0] fr_rdata;

   // ports
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_wa, mem_ra;
   logic [7:0]              mem_wd;
   logic                    gp_we;
   logic [3:0]              gp_wa, gp_ra;
   logic [7:0]              gp_wd;
   logic                    fr_we, fr_clr;
   logic [ROW_W-1:0]        fr_wa, fr_ra;
   logic [SCREEN_WIDTH-1:0] fr_wd;
   logic                    stack_we;

   // architectural and sequencing state
   logic [4:0]        state_ff, state_in;
   q_item_type        item_ff, item_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [15:0]       idx_ff, idx_in;
   logic [3:0]        sp_ff, sp_in;
   logic [7:0]        dt_ff, dt_in;
   logic [7:0]        st_ff, st_in;
   logic [15:0]       op_ff, op_in;
   logic [7:0]        vx_ff, vx_in;
   logic [7:0]        vy_ff, vy_in;
   logic [7:0]        flag_ff, flag_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [3:0]        lp_ff, lp_in;
   logic [11:0]       bcd_ff, bcd_in;
   logic              drew_ff, drew_in;
   logic              wait_ff, wait_in;
   logic              bad_ff, bad_in;

   // result register
   logic              rsp_vld_ff;
   logic [63:0]       rsp_row_ff;
   logic [ADDR_W-1:0] rsp_pc_ff;
   logic              rsp_drew_ff, rsp_snd_ff, rsp_wait_ff, rsp_bad_ff;
   logic              rsp_load;

   // decode helpers
   logic [3:0]        grp, xi, yi, nn;
   logic [7:0]        kk;
   logic [ADDR_W-1:0] nnn, pc2, pc4, pc_sp;
   logic [7:0]        dt_base, st_base;
   logic [8:0]        sum9;
   logic              key_hit;
   logic [5:0]        row6;
   logic [63:0]       bits;
   logic [ADDR_W-1:0] idx_lp;

   function automatic logic [3:0] lowest_key(input logic [15:0] k);
      logic [3:0] r;
      r = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (k[i]) begin
            r = 4'(i);
         end
      end
      return r;
   endfunction

   assign gp_rdata = gp_rdv_ff ? gp_rd_ff : 8'h00;
   assign fr_rdata = fr_rdv_ff ? fr_rd_ff : '0;

   assign grp    = op_ff[15:12];
   assign xi     = op_ff[11:8];
   assign yi     = op_ff[7:4];
   assign nn     = op_ff[3:0];
   assign kk     = op_ff[7:0];
   assign nnn    = op_ff[ADDR_W-1:0];
   assign pc2    = pc_ff + ADDR_W'(2);
   assign pc4    = pc_ff + ADDR_W'(4);
   assign pc_sp  = stack_ff[sp_ff - 4'd1];
   assign sum9   = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign key_hit = (vx_ff < 8'd16) && item_ff.key_mask[vx_ff[3:0]];
   assign row6   = {1'b0, vy_ff[ROW_W-1:0]} + {2'b0, lp_ff};
   assign bits   = {mem_rd_ff, 56'b0} >> vx_ff[5:0];
   assign idx_lp = idx_ff[ADDR_W-1:0] + {8'b0, lp_ff};

   assign stat.clearing = (state_ff == S_CLEAR);
   assign rsp_load      = (state_ff == S_RESP) && (!rsp_vld_ff || rsp_ch.ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      pc_in    = pc_ff;
      idx_in   = idx_ff;
      sp_in    = sp_ff;
      dt_in    = dt_ff;
      st_in    = st_ff;
      op_in    = op_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      flag_in  = flag_ff;
      clr_in   = clr_ff;
      lp_in    = lp_ff;
      bcd_in   = bcd_ff;
      drew_in  = drew_ff;
      wait_in  = wait_ff;
      bad_in   = bad_ff;
      dt_base  = dt_ff;
      st_base  = st_ff;
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = idx_lp;
      mem_wd   = 8'h00;
      mem_ra   = pc_ff;
      gp_we    = 1'b0;
      gp_wa    = xi;
      gp_wd    = 8'h00;
      gp_ra    = xi;
      fr_we    = 1'b0;
      fr_clr   = 1'b0;
      fr_wa    = row6[ROW_W-1:0];
      fr_wd    = fr_rdata ^ bits;
      fr_ra    = item_ff.row_select;
      stack_we = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep memory, loading the font
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = font_byte(clr_ff);
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               drew_in = 1'b0;
               wait_in = 1'b0;
               bad_in  = 1'b0;
               unique case (q_item.kind)
                  K_LOAD: begin
                     mem_we   = 1'b1;
                     mem_wa   = q_item.load_addr;
                     mem_wd   = q_item.load_data;
                     state_in = S_ROW;
                  end
                  K_EXEC:  state_in = S_FETCH_H;
                  default: state_in = S_ROW;
               endcase
            end
         end
         S_FETCH_H: begin
            op_in[15:8] = mem_rd_ff;
            mem_ra      = pc_ff + ADDR_W'(1);
            state_in    = S_FETCH_L;
         end
         S_FETCH_L: begin
            op_in[7:0] = mem_rd_ff;
            gp_ra      = op_ff[11:8];
            state_in   = S_READ_X;
         end
         S_READ_X: begin
            // Bnnn needs V0 in place of Vy
            vx_in    = gp_rdata;
            gp_ra    = (grp == OP_JPV0) ? 4'd0 : yi;
            state_in = S_READ_Y;
         end
         S_READ_Y: begin
            vy_in    = gp_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            pc_in    = pc2;
            state_in = S_ROW;
            unique case (grp)
               OP_SYS: begin
                  if (op_ff == OP_CLS) begin
                     fr_clr  = 1'b1;
                     drew_in = 1'b1;
                  end else if (op_ff == OP_RET) begin
                     sp_in = sp_ff - 4'd1;
                     pc_in = pc_sp;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               OP_JP: pc_in = nnn;
               OP_CALL: begin
                  stack_we = 1'b1;
                  sp_in    = sp_ff + 4'd1;
                  pc_in    = nnn;
               end
               OP_SE:  if (vx_ff == kk) pc_in = pc4;
               OP_SNE: if (vx_ff != kk) pc_in = pc4;
               OP_SEXY: begin
                  if (nn != 4'd0) bad_in = 1'b1;
                  else if (vx_ff == vy_ff) pc_in = pc4;
               end
               OP_LD: begin
                  gp_we = 1'b1;
                  gp_wd = kk;
               end
               OP_ADD: begin
                  gp_we = 1'b1;
                  gp_wd = vx_ff + kk;
               end
               OP_ALU: begin
                  gp_we = 1'b1;
                  case (nn)
                     ALU_MOV: gp_wd = vy_ff;
                     ALU_OR:  gp_wd = vx_ff | vy_ff;
                     ALU_AND: gp_wd = vx_ff & vy_ff;
                     ALU_XOR: gp_wd = vx_ff ^ vy_ff;
                     ALU_ADD: begin
                        gp_wd    = sum9[7:0];
                        flag_in  = {7'b0, sum9[8]};
                        state_in = S_FLAG;
                     end
                     ALU_SUB: begin
                        gp_wd    = vx_ff - vy_ff;
                        flag_in  = {7'b0, vx_ff > vy_ff};
                        state_in = S_FLAG;
                     end
                     ALU_SHR: begin
                        gp_wd    = {1'b0, vx_ff[7:1]};
                        flag_in  = {7'b0, vx_ff[0]};
                        state_in = S_FLAG;
                     end
                     ALU_RSB: begin
                        gp_wd    = vy_ff - vx_ff;
                        flag_in  = {7'b0, vy_ff > vx_ff};
                        state_in = S_FLAG;
                     end
                     ALU_SHL: begin
                        gp_wd    = {vx_ff[6:0], 1'b0};
                        flag_in  = {7'b0, vx_ff[7]};
                        state_in = S_FLAG;
                     end
                     default: begin
                        gp_we  = 1'b0;
                        bad_in = 1'b1;
                     end
                  endcase
               end
               OP_SNEXY: begin
                  if (nn != 4'd0) bad_in = 1'b1;
                  else if (vx_ff != vy_ff) pc_in = pc4;
               end
               OP_LDI:  idx_in = {4'b0, nnn};
               OP_JPV0: pc_in = nnn + {4'b0, vy_ff};
               OP_RND: begin
                  gp_we = 1'b1;
                  gp_wd = item_ff.rand_byte & kk;
               end
               OP_DRW: begin
                  drew_in  = 1'b1;
                  flag_in  = 8'h00;
                  lp_in    = 4'd0;
                  state_in = S_DRAW_A;
               end
               OP_SKP: begin
                  if (kk == SKP_DOWN) begin
                     if (key_hit) pc_in = pc4;
                  end else if (kk == SKP_UP) begin
                     if (!key_hit) pc_in = pc4;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               default: begin
                  unique case (kk)
                     FX_GETDT: begin
                        gp_we = 1'b1;
                        gp_wd = dt_ff;
                     end
                     FX_KEY: begin
                        if (item_ff.key_mask != 16'h0) begin
                           gp_we = 1'b1;
                           gp_wd = {4'b0, lowest_key(item_ff.key_mask)};
                        end else begin
                           pc_in   = pc_ff;
                           wait_in = 1'b1;
                        end
                     end
                     FX_SETDT: dt_base = vx_ff;
                     FX_SETST: st_base = vx_ff;
                     FX_ADDI:  idx_in = idx_ff + {8'b0, vx_ff};
                     FX_FONT:  idx_in = {4'b0, FONT_BASE} + {6'b0, vx_ff, 2'b0}
                                        + {8'b0, vx_ff};
                     FX_BCD: begin
                        bcd_in   = bcd_digits(vx_ff);
                        lp_in    = 4'd0;
                        state_in = S_BCD;
                     end
                     FX_STORE: begin
                        lp_in    = 4'd0;
                        state_in = S_STORE_A;
                     end
                     FX_LOAD: begin
                        lp_in    = 4'd0;
                        state_in = S_LOAD_A;
                     end
                     default: bad_in = 1'b1;
                  endcase
               end
            endcase
            // step timers after the instruction
            dt_in = (dt_base != 8'h00) ? dt_base - 8'd1 : 8'h00;
            st_in = (st_base != 8'h00) ? st_base - 8'd1 : 8'h00;
         end
         S_FLAG: begin
            gp_we    = 1'b1;
            gp_wa    = 4'hF;
            gp_wd    = flag_ff;
            state_in = S_ROW;
         end
         S_DRAW_A: begin
            // stop at sprite height or bottom edge, then write collision flag
            if (lp_ff == nn || row6[ROW_W]) begin
               gp_we    = 1'b1;
               gp_wa    = 4'hF;
               gp_wd    = flag_ff;
               state_in = S_ROW;
            end else begin
               mem_ra   = idx_lp;
               fr_ra    = row6[ROW_W-1:0];
               state_in = S_DRAW_B;
            end
         end
         S_DRAW_B: begin
            fr_we = 1'b1;
            if ((fr_rdata & bits) != '0) begin
               flag_in = 8'h01;
            end
            lp_in    = lp_ff + 4'd1;
            state_in = S_DRAW_A;
         end
         S_BCD: begin
            mem_we = 1'b1;
            case (lp_ff)
               4'd0:    mem_wd = {4'b0, bcd_ff[11:8]};
               4'd1:    mem_wd = {4'b0, bcd_ff[7:4]};
               default: mem_wd = {4'b0, bcd_ff[3:0]};
            endcase
            lp_in = lp_ff + 4'd1;
            if (lp_ff == 4'd2) begin
               state_in = S_ROW;
            end
         end
         S_STORE_A: begin
            gp_ra    = lp_ff;
            state_in = S_STORE_B;
         end
         S_STORE_B: begin
            mem_we   = 1'b1;
            mem_wd   = gp_rdata;
            lp_in    = lp_ff + 4'd1;
            state_in = (lp_ff == xi) ? S_ROW : S_STORE_A;
         end
         S_LOAD_A: begin
            mem_ra   = idx_lp;
            state_in = S_LOAD_B;
         end
         S_LOAD_B: begin
            gp_we    = 1'b1;
            gp_wa    = lp_ff;
            gp_wd    = mem_rd_ff;
            lp_in    = lp_ff + 4'd1;
            state_in = (lp_ff == xi) ? S_ROW : S_LOAD_A;
         end
         S_ROW: state_in = S_RESP;
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         pc_ff      <= START_PC;
         idx_ff     <= '0;
         sp_ff      <= '0;
         dt_ff      <= '0;
         st_ff      <= '0;
         gp_vld_ff  <= '0;
         fr_vld_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         idx_ff   <= idx_in;
         sp_ff    <= sp_in;
         dt_ff    <= dt_in;
         st_ff    <= st_in;
         if (gp_we) begin
            gp_vld_ff[gp_wa] <= 1'b1;
         end
         if (fr_clr) begin
            fr_vld_ff <= '0;
         end else if (fr_we) begin
            fr_vld_ff[fr_wa] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      op_ff   <= op_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      flag_ff <= flag_in;
      lp_ff   <= lp_in;
      bcd_ff  <= bcd_in;
      drew_ff <= drew_in;
      wait_ff <= wait_in;
      bad_ff  <= bad_in;
      if (stack_we) begin
         stack_ff[sp_ff] <= pc2;
      end
      if (rsp_load) begin
         rsp_row_ff  <= fr_rdata;
         rsp_pc_ff   <= pc_ff;
         rsp_drew_ff <= drew_ff;
         rsp_snd_ff  <= (st_ff != 8'h00);
         rsp_wait_ff <= wait_ff;
         rsp_bad_ff  <= bad_ff;
      end
   end

   // main memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem_ff[mem_ra];
   end

   // register file
   always_ff @(posedge clock) begin
      if (gp_we) begin
         gp_ff[gp_wa] <= gp_wd;
      end
      gp_rd_ff  <= gp_ff[gp_ra];
      gp_rdv_ff <= gp_vld_ff[gp_ra];
   end

   // frame buffer
   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_ff[fr_wa] <= fr_wd;
      end
      fr_rd_ff  <= frame_ff[fr_ra];
      fr_rdv_ff <= fr_vld_ff[fr_ra] && !fr_clr;
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.row_pixels = rsp_row_ff;
   assign rsp_ch.pc_now     = rsp_pc_ff;
   assign rsp_ch.draw_flag  = rsp_drew_ff;
   assign rsp_ch.sound_on   = rsp_snd_ff;
   assign rsp_ch.key_wait   = rsp_wait_ff;
   assign rsp_ch.bad_opcode = rsp_bad_ff;

endmodule

// File: hw/rtl/chip8_cpu_step.sv
// Channel | Dir | Carries
// req_ch  | in  | cmd, load_addr, load_data, row_select, key_mask, rand_byte
// rsp_ch  | out | row_pixels, pc_now, draw_flag, sound_on, key_wait, bad_opcode
//
// Load and row read pass from queue pop through the row and response states to the result;
// an instruction fetches, reads Vx and Vy and executes, and Dxyn adds states per sprite row,
// Fx55/Fx65 per register, Fx33 per digit, and an 8xy flag op a flag write, all in one sequencer.
// After reset a clearing pass writes the font and zeros the rest of memory; req_ch.ready stays low.
// A 2-beat queue lets requests arrive while an item executes; a held result stalls the back end.
`include "chip8_cpu_step_assert.svh"
module chip8_cpu_step import c8_pkg::*; (
   input logic      clock,
   input logic      reset,
   c8_req_if.sink   req_ch,
   c8_rsp_if.source rsp_ch
);

   stat_type   stat;
   logic       q_valid;
   logic       q_pop;
   q_item_type q_item;

   c8_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .stat   (stat),
      .q_valid(q_valid),
      .q_item (q_item),
      .q_pop  (q_pop)
   );

   c8_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .q_valid(q_valid),
      .q_item (q_item),
      .q_pop  (q_pop),
      .stat   (stat),
      .rsp_ch (rsp_ch)
   );

   `C8_ASSERT_IMP(a_no_accept_clear, stat.clearing, !req_ch.ready)
   `C8_ASSERT_IMP(a_queue_empty_clear, stat.clearing, !q_valid)
   `C8_ASSERT_NXT(a_pop_leaves_clear, q_pop, !stat.clearing)
   `C8_ASSERT_IMP(a_wait_alone, rsp_ch.valid && rsp_ch.key_wait,
                  !rsp_ch.draw_flag && !rsp_ch.bad_opcode)

endmodule
